@@ rtl/assert_macros.svh @@
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

`define LFA_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

`define LFA_ASSERT_ALWAYS(name, prop, msg) \
  name: assert property (@(posedge clk) prop) else $error(msg);

`else

`define LFA_ASSERT(name, prop, msg)

`define LFA_ASSERT_ALWAYS(name, prop, msg)

`endif

`endif

@@ rtl/lfa_pkg.sv @@
package lfa_pkg;

  localparam int CNT_W   = 11;
  localparam int NUM_W   = 10;
  localparam int KIND_W  = 2;
  localparam int WORD_W  = 32;
  localparam int BIT_W   = 5;
  localparam int WIDX_W  = CNT_W - BIT_W;
  localparam int IN_W    = 16;
  localparam int OUT_W   = 16;
  localparam int CNT_RST = 1024;

  localparam logic [CNT_W-1:0] NONE_ID = '1;

  typedef enum logic [KIND_W-1:0] {
    KIND_ALLOC   = 2'd0,
    KIND_CHECK   = 2'd1,
    KIND_RELEASE = 2'd2
  } kind_t;

  typedef enum logic [4:0] {
    ST_CLEAR = 5'b00001,
    ST_IDLE  = 5'b00010,
    ST_MOD   = 5'b00100,
    ST_SCAN  = 5'b01000,
    ST_DONE  = 5'b10000
  } state_t;

  typedef struct packed {
    logic             found;
    logic [BIT_W-1:0] idx;
  } ffs_t;

endpackage

@@ rtl/lowest_free_id_allocator.sv @@
// Lowest-free ID allocator. IDs 0..count-1 live in a bitmap held in one
// synchronous RAM of 32-bit words. Allocate returns the tracked lowest free
// ID, clears its bit and then scans upward one RAM word per cycle for the next
// free ID; an allocate passes through the states MOD, then SCAN once per
// further word to be scanned, then DONE. Check and release pass through MOD
// and DONE; an out-of-range or unused request, or an allocate from an empty
// pool, goes straight to DONE. The next item is taken once the current one
// is done; its result then sits in the output register until taken.
// After reset and after every write of the count register the RAM is swept
// to all free, one word per cycle, and no item is accepted meanwhile.
// Counts are clamped to 1..MAX_NUMBERS.
`include "assert_macros.svh"

module lowest_free_id_allocator #(
  parameter int MAX_NUMBERS = 1024
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [15:0] s_tdata,   // [9:0] number
  input  logic [1:0]  s_tuser,   // [1:0] kind
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata,   // [10:0] granted_number, [11] is_free, [12] out_of_range
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [10:0] cfg_data
);

  localparam int CNT_W  = lfa_pkg::CNT_W;
  localparam int NUM_W  = lfa_pkg::NUM_W;
  localparam int WORD_W = lfa_pkg::WORD_W;
  localparam int BIT_W  = lfa_pkg::BIT_W;
  localparam int WIDX_W = lfa_pkg::WIDX_W;
  localparam int OUT_W  = lfa_pkg::OUT_W;
  localparam int WORDS  = (MAX_NUMBERS + WORD_W - 1) / WORD_W;
  localparam int AW     = (WORDS > 1) ? $clog2(WORDS) : 1;
  localparam int CNT_MAX_I = (MAX_NUMBERS < (1 << CNT_W) - 1) ? MAX_NUMBERS : (1 << CNT_W) - 1;
  localparam int CNT_RST_I = (MAX_NUMBERS < lfa_pkg::CNT_RST) ? MAX_NUMBERS : lfa_pkg::CNT_RST;
  localparam logic [CNT_W-1:0] CNT_MAX   = CNT_W'(CNT_MAX_I);
  localparam logic [CNT_W-1:0] CNT_RESET = CNT_W'(CNT_RST_I);
  localparam logic [AW-1:0]    LAST_ADDR = AW'(WORDS - 1);

  function automatic logic [WORD_W-1:0] count_mask(input logic [WIDX_W-1:0] w,
                                                   input logic [CNT_W-1:0]  c);
    logic [CNT_W:0]      diff;
    logic [WORD_W-1:0]   m;
    diff = {1'b0, c} - {1'b0, w, {BIT_W{1'b0}}};
    if (diff[CNT_W] || diff == '0) begin
      m = '0;
    end else if (diff >= (CNT_W + 1)'(WORD_W)) begin
      m = '1;
    end else begin
      m = (WORD_W'(1) << diff[BIT_W-1:0]) - WORD_W'(1);
    end
    return m;
  endfunction

  function automatic lfa_pkg::ffs_t find_first(input logic [WORD_W-1:0] v);
    lfa_pkg::ffs_t r;
    r.found = |v;
    r.idx   = '0;
    for (int i = WORD_W - 1; i >= 0; i--) begin
      if (v[i]) r.idx = BIT_W'(i);
    end
    return r;
  endfunction

  function automatic logic is_last(input logic [WIDX_W-1:0] w, input logic [CNT_W-1:0] c);
    logic [WIDX_W:0] nw;
    nw = {1'b0, w} + (WIDX_W + 1)'(1);
    return {nw, {BIT_W{1'b0}}} >= {1'b0, c};
  endfunction

  lfa_pkg::state_t state, state_next;
  lfa_pkg::kind_t  op_kind;
  logic [CNT_W-1:0]  op_num;
  logic [CNT_W-1:0]  count_reg;
  logic [CNT_W-1:0]  lowest_free, lowest_free_next;
  logic              pool_empty, pool_empty_next;
  logic [WIDX_W-1:0] scan_word, scan_word_next;
  logic [AW-1:0]     clr_addr;
  logic [CNT_W-1:0]  res_granted, res_granted_next;
  logic              res_free, res_free_next;
  logic              res_oor, res_oor_next;
  logic [OUT_W-1:0]  out_data;
  logic              out_valid;

  logic [WORD_W-1:0] mem [WORDS];
  logic [WORD_W-1:0] rdata;
  logic [WIDX_W-1:0] rd_word;
  logic              mem_we;
  logic [AW-1:0]     waddr;
  logic [WORD_W-1:0] wdata;

  logic [CNT_W-1:0]  in_num;
  logic              in_acc, cfg_acc, out_load;
  logic [CNT_W-1:0]  cfg_clamped;
  logic [WORD_W-1:0] bit_sel, cand;
  lfa_pkg::ffs_t     hit;

  assign in_num    = {1'b0, s_tdata[NUM_W-1:0]};
  assign s_tready  = (state == lfa_pkg::ST_IDLE);
  assign in_acc    = s_tvalid && s_tready;
  assign cfg_ready = 1'b1;
  assign cfg_acc   = cfg_valid && cfg_ready;
  assign out_load  = (state == lfa_pkg::ST_DONE) && (!out_valid || m_tready);
  assign m_tvalid  = out_valid;
  assign m_tdata   = out_data;

  always_comb begin
    if (cfg_data == '0) begin
      cfg_clamped = CNT_W'(1);
    end else if (cfg_data > CNT_MAX) begin
      cfg_clamped = CNT_MAX;
    end else begin
      cfg_clamped = cfg_data;
    end
  end

  always_comb begin
    state_next       = state;
    lowest_free_next = lowest_free;
    pool_empty_next  = pool_empty;
    scan_word_next   = scan_word;
    res_granted_next = res_granted;
    res_free_next    = res_free;
    res_oor_next     = res_oor;
    rd_word          = scan_word;
    mem_we           = 1'b0;
    waddr            = clr_addr;
    wdata            = '1;
    bit_sel          = WORD_W'(1) << op_num[BIT_W-1:0];
    cand             = '0;
    hit              = find_first(cand);
    case (state)
      lfa_pkg::ST_CLEAR: begin
        mem_we = 1'b1;
        if (clr_addr == LAST_ADDR) state_next = lfa_pkg::ST_IDLE;
      end
      lfa_pkg::ST_IDLE: begin
        rd_word = (lfa_pkg::kind_t'(s_tuser) == lfa_pkg::KIND_ALLOC) ?
                  lowest_free[CNT_W-1:BIT_W] : in_num[CNT_W-1:BIT_W];
        if (in_acc) begin
          res_granted_next = lfa_pkg::NONE_ID;
          res_free_next    = 1'b0;
          res_oor_next     = 1'b0;
          state_next       = lfa_pkg::ST_DONE;
          case (s_tuser)
            lfa_pkg::KIND_ALLOC: begin
              if (!pool_empty && lowest_free < count_reg) state_next = lfa_pkg::ST_MOD;
            end
            lfa_pkg::KIND_CHECK, lfa_pkg::KIND_RELEASE: begin
              if (in_num >= count_reg) res_oor_next = 1'b1;
              else                     state_next   = lfa_pkg::ST_MOD;
            end
            default: ;
          endcase
        end
      end
      lfa_pkg::ST_MOD: begin
        state_next = lfa_pkg::ST_DONE;
        case (op_kind)
          lfa_pkg::KIND_CHECK: begin
            res_free_next = |(rdata & bit_sel);
          end
          lfa_pkg::KIND_RELEASE: begin
            mem_we = 1'b1;
            waddr  = AW'(op_num[CNT_W-1:BIT_W]);
            wdata  = rdata | bit_sel;
            if (pool_empty || op_num < lowest_free) begin
              lowest_free_next = op_num;
              pool_empty_next  = 1'b0;
            end
          end
          default: begin
            bit_sel          = WORD_W'(1) << lowest_free[BIT_W-1:0];
            mem_we           = 1'b1;
            waddr            = AW'(lowest_free[CNT_W-1:BIT_W]);
            wdata            = rdata & ~bit_sel;
            res_granted_next = lowest_free;
            cand = rdata & (({WORD_W{1'b1}} << lowest_free[BIT_W-1:0]) << 1)
                   & count_mask(lowest_free[CNT_W-1:BIT_W], count_reg);
            hit  = find_first(cand);
            rd_word = lowest_free[CNT_W-1:BIT_W] + WIDX_W'(1);
            if (hit.found) begin
              lowest_free_next = {lowest_free[CNT_W-1:BIT_W], hit.idx};
            end else if (is_last(lowest_free[CNT_W-1:BIT_W], count_reg)) begin
              pool_empty_next = 1'b1;
            end else begin
              scan_word_next = rd_word;
              state_next     = lfa_pkg::ST_SCAN;
            end
          end
        endcase
      end
      lfa_pkg::ST_SCAN: begin
        cand    = rdata & count_mask(scan_word, count_reg);
        hit     = find_first(cand);
        rd_word = scan_word + WIDX_W'(1);
        if (hit.found) begin
          lowest_free_next = {scan_word, hit.idx};
          state_next       = lfa_pkg::ST_DONE;
        end else if (is_last(scan_word, count_reg)) begin
          pool_empty_next = 1'b1;
          state_next      = lfa_pkg::ST_DONE;
        end else begin
          scan_word_next = rd_word;
        end
      end
      lfa_pkg::ST_DONE: begin
        if (out_load) state_next = lfa_pkg::ST_IDLE;
      end
      default: state_next = lfa_pkg::ST_CLEAR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) mem[waddr] <= wdata;
    rdata <= mem[AW'(rd_word)];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= lfa_pkg::ST_CLEAR;
      clr_addr    <= '0;
      count_reg   <= CNT_RESET;
      lowest_free <= '0;
      pool_empty  <= 1'b0;
      out_valid   <= 1'b0;
    end else begin
      if (cfg_acc) begin
        state       <= lfa_pkg::ST_CLEAR;
        clr_addr    <= '0;
        count_reg   <= cfg_clamped;
        lowest_free <= '0;
        pool_empty  <= 1'b0;
      end else begin
        state       <= state_next;
        lowest_free <= lowest_free_next;
        pool_empty  <= pool_empty_next;
        if (state == lfa_pkg::ST_CLEAR) clr_addr <= clr_addr + AW'(1);
      end
      if (out_load)      out_valid <= 1'b1;
      else if (m_tready) out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    scan_word   <= scan_word_next;
    res_granted <= res_granted_next;
    res_free    <= res_free_next;
    res_oor     <= res_oor_next;
    if (in_acc) begin
      op_kind <= lfa_pkg::kind_t'(s_tuser);
      op_num  <= in_num;
    end
    if (out_load) begin
      out_data <= {(OUT_W - CNT_W - 2)'(0), res_oor, res_free, res_granted};
    end
  end

  `LFA_ASSERT(a_load_from_done, $rose(m_tvalid) |-> $past(state == lfa_pkg::ST_DONE), "result loaded outside done")
  `LFA_ASSERT(a_lowest_in_range, (state == lfa_pkg::ST_IDLE && !pool_empty) |-> (lowest_free < count_reg), "lowest free beyond count")
  `LFA_ASSERT(a_cfg_clears, cfg_acc |=> (state == lfa_pkg::ST_CLEAR && lowest_free == '0 && !pool_empty), "count write did not clear pool")
  `LFA_ASSERT_ALWAYS(a_reset_state, rst |=> (state == lfa_pkg::ST_CLEAR && !m_tvalid && !s_tready), "bad state after reset")

endmodule

@@ tb/sv/tb_lowest_free_id_allocator.sv @@
`timescale 1ns / 1ps

module tb_lowest_free_id_allocator;
  import lfa_pkg::*;

  localparam int MAX_IDS = 1024;
  localparam int STALL_LEN = 400;
  localparam int QUIET_LIMIT = 4000;
  localparam int DRAIN_CYCLES = 64;
  localparam int SEG_ITEMS = 70;
  localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;

  typedef struct packed {
    logic [CNT_W-1:0] granted;
    logic             is_free;
    logic             out_of_range;
  } response_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [15:0] s_tdata = '0;   // [9:0] number
  logic [1:0]  s_tuser = '0;   // [1:0] kind
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [15:0] m_tdata;        // [10:0] granted_number, [11] is_free, [12] out_of_range
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [10:0] cfg_data = '0;

  // shadow of the allocator state
  bit               id_free [MAX_IDS];
  logic [CNT_W-1:0] pool_lowest;
  bit               pool_empty;
  int unsigned      pool_size;

  response_t expected_responses[$];
  int        mismatches = 0;
  int        send_idle_pct = 0;
  int        recv_idle_pct = 0;
  int        stall_seq = 0;
  int        stall_seen = 0;
  int        stall_left = 0;
  int        quiet_cycles = 0;

  lowest_free_id_allocator #(.MAX_NUMBERS(MAX_IDS)) dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data (cfg_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic void set_pool_size(input logic [10:0] v);
    if (v == 0) pool_size = 1;
    else if (v > MAX_IDS) pool_size = MAX_IDS;
    else pool_size = 32'(v);
    foreach (id_free[i]) id_free[i] = 1'b1;
    pool_lowest = '0;
    pool_empty = 1'b0;
  endfunction

  function automatic response_t allocator_response(input logic [1:0] k, input logic [9:0] n);
    response_t   r;
    int unsigned i;
    bit          found;
    r.granted = NONE_ID;
    r.is_free = 1'b0;
    r.out_of_range = 1'b0;
    found = 1'b0;
    if (k == KIND_ALLOC) begin
      if (!pool_empty && pool_lowest < pool_size) begin
        r.granted = pool_lowest;
        for (i = pool_lowest + 1; i < pool_size && !found; i++) begin
          if (id_free[i]) begin
            pool_lowest = CNT_W'(i);
            found = 1'b1;
          end
        end
        if (!found) pool_empty = 1'b1;
        id_free[r.granted] = 1'b0;
      end
    end else if (k == KIND_CHECK || k == KIND_RELEASE) begin
      if (n >= pool_size) begin
        r.out_of_range = 1'b1;
      end else if (k == KIND_CHECK) begin
        r.is_free = id_free[n];
      end else begin
        id_free[n] = 1'b1;
        if (pool_empty) begin
          pool_lowest = {1'b0, n};
          pool_empty = 1'b0;
        end else if (n < pool_lowest) begin
          pool_lowest = {1'b0, n};
        end
      end
    end
    return r;
  endfunction

  task automatic send_request(input logic [1:0] k, input logic [9:0] n);
    while ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser <= k;
    s_tdata <= {6'd0, n};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    expected_responses.push_back(allocator_response(k, n));
  endtask

  task automatic wait_drained();
    s_tvalid <= 1'b0;
    while (expected_responses.size() != 0) @(posedge clk);
  endtask

  task automatic write_pool_size(input logic [10:0] v);
    wait_drained();
    cfg_valid <= 1'b1;
    cfg_data <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    set_pool_size(v);
  endtask

  // reset count, allocate/check/release basics, unused kind
  task automatic test_default_pool();
    send_request(KIND_ALLOC, 10'h3FF);
    send_request(KIND_ALLOC, 10'h000);
    send_request(KIND_ALLOC, 10'h155);
    send_request(KIND_CHECK, 10'd1);
    send_request(KIND_CHECK, 10'd1023);
    send_request(KIND_RELEASE, 10'd1);
    send_request(KIND_CHECK, 10'd1);
    send_request(KIND_ALLOC, 10'h2AA);
    send_request(KIND_RELEASE, 10'd1023);
    send_request(KIND_UNUSED, 10'h3FF);
    send_request(KIND_RELEASE, 10'd0);
    send_request(KIND_ALLOC, 10'h000);
    send_request(KIND_CHECK, 10'd0);
  endtask

  // count clamping, exhausted pool, release while empty, out of range
  task automatic test_count_limits();
    write_pool_size(11'd0);
    send_request(KIND_ALLOC, 10'd0);
    send_request(KIND_ALLOC, 10'd0);
    send_request(KIND_CHECK, 10'd0);
    send_request(KIND_CHECK, 10'd1);
    send_request(KIND_RELEASE, 10'd0);
    send_request(KIND_ALLOC, 10'd0);
    send_request(KIND_RELEASE, 10'd1023);
    send_request(KIND_UNUSED, 10'd0);
    write_pool_size(11'd2047);
    send_request(KIND_CHECK, 10'd1023);
    send_request(KIND_ALLOC, 10'd0);
  endtask

  // receiver holds off while the sender keeps offering
  task automatic test_backpressure();
    int saved_pct;
    saved_pct = send_idle_pct;
    wait_drained();
    send_idle_pct = 0;
    stall_seq++;
    for (int i = 0; i < 12; i++) begin
      send_request((i % 3 == 2) ? KIND_CHECK : KIND_ALLOC, 10'($urandom_range(pool_size - 1)));
    end
    send_idle_pct = saved_pct;
  endtask

  task automatic test_random_mix(input logic [10:0] size_val);
    int          alloc_pct;
    int          pick;
    logic [9:0]  n;
    int unsigned start;
    bit          got;
    write_pool_size(size_val);
    alloc_pct = $urandom_range(30, 70);
    for (int i = 0; i < SEG_ITEMS; i++) begin
      pick = $urandom_range(99);
      if ($urandom_range(3) == 0) n = 10'($urandom);
      else n = 10'($urandom_range(pool_size - 1));
      if (pick < alloc_pct) begin
        send_request(KIND_ALLOC, 10'($urandom));
      end else if (pick < alloc_pct + 15) begin
        send_request(KIND_CHECK, n);
      end else if (pick < 97) begin
        // mostly release an id that is actually held
        if ($urandom_range(3) != 0) begin
          start = $urandom_range(pool_size - 1);
          got = 1'b0;
          for (int j = 0; j < pool_size && !got; j++) begin
            if (!id_free[(start + j) % pool_size]) begin
              n = 10'((start + j) % pool_size);
              got = 1'b1;
            end
          end
        end
        send_request(KIND_RELEASE, n);
      end else begin
        send_request(KIND_UNUSED, n);
      end
    end
  endtask

  always @(posedge clk) begin
    response_t exp_r;
    response_t act_r;
    if (!rst && m_tvalid && m_tready) begin
      act_r.granted = m_tdata[10:0];
      act_r.is_free = m_tdata[11];
      act_r.out_of_range = m_tdata[12];
      if (expected_responses.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected result, actual granted %0d is_free %0b out_of_range %0b",
                 $time, $signed(act_r.granted), act_r.is_free, act_r.out_of_range);
      end else begin
        exp_r = expected_responses.pop_front();
        if (act_r.granted !== exp_r.granted) begin
          mismatches++;
          $display("%0t: granted_number expected %0d actual %0d",
                   $time, $signed(exp_r.granted), $signed(act_r.granted));
        end
        if (act_r.is_free !== exp_r.is_free) begin
          mismatches++;
          $display("%0t: is_free expected %0b actual %0b", $time, exp_r.is_free, act_r.is_free);
        end
        if (act_r.out_of_range !== exp_r.out_of_range) begin
          mismatches++;
          $display("%0t: out_of_range expected %0b actual %0b",
                   $time, exp_r.out_of_range, act_r.out_of_range);
        end
      end
    end
    if (stall_seq != stall_seen) begin
      stall_seen = stall_seq;
      stall_left = STALL_LEN;
    end
    if (stall_left > 0) begin
      stall_left--;
      m_tready <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("TEST FAILED");
        $finish;
      end
    end
  end

  initial begin
    set_pool_size(11'(CNT_RST));
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    test_default_pool();
    test_count_limits();
    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin
          send_idle_pct = 26;
          recv_idle_pct = 88;
        end
        1: begin
          send_idle_pct = 88;
          recv_idle_pct = 26;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase
      test_random_mix(11'($urandom_range(2, 40)));
      if (phase == 0) test_backpressure();
      test_random_mix(11'($urandom_range(1, 8)));
      test_random_mix(11'($urandom_range(33, 100)));
      case (phase)
        0: test_random_mix(11'd1024);
        1: test_random_mix(11'($urandom_range(100, 1023)));
        default: test_random_mix(11'd2047);
      endcase
    end
    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

@@ sim.f @@
+incdir+rtl
rtl/lfa_pkg.sv
rtl/lowest_free_id_allocator.sv
tb/sv/tb_lowest_free_id_allocator.sv
